FILE: rtl/core/qrs_pkg.sv
// Quadratic root solver package: shared widths, result codes and sideband types.
// No dependencies.
package qrs_pkg;

    localparam int COEF_W    = 32;
    localparam int TOL_W     = 32;
    localparam int DM_W      = 65;
    localparam int RAD_W     = 66;
    localparam int ROOT_W    = 33;
    localparam int REM_W     = 35;
    localparam int SQ_STEPS  = 33;
    localparam int NUM_W     = 35;
    localparam int DEN_W     = 34;
    localparam int NMAG_W    = 34;
    localparam int DMAG_W    = 33;
    localparam int DIV_STEPS = 32;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

    typedef struct packed {
        logic [1:0] count;
        logic       use1;
        logic       use2;
    } t_tail;

    typedef struct packed {
        t_tail                   tail;
        logic                    two;
        logic signed [NUM_W-1:0] base;
        logic signed [DEN_W-1:0] den;
    } t_side;

endpackage

FILE: rtl/core/qrs_isqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Depends on qrs_pkg; carries a t_side sideband alongside the radicand.
module qrs_isqrt import qrs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_side             i_side,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic [REM_W-1:0]  r_rem  [SQ_STEPS];
    logic [ROOT_W-1:0] r_root [SQ_STEPS];
    logic [RAD_W-1:0]  r_rad  [SQ_STEPS];
    t_side             r_side [SQ_STEPS];
    logic [REM_W-1:0]  n_rem  [SQ_STEPS];
    logic [ROOT_W-1:0] n_root [SQ_STEPS];
    logic [RAD_W-1:0]  n_rad  [SQ_STEPS];
    t_side             n_side [SQ_STEPS];

    always_comb begin
        logic [REM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [RAD_W-1:0]  p_rad;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        for (int k = 0; k < SQ_STEPS; k++) begin
            if (k == 0) begin
                p_rem     = '0;
                p_root    = '0;
                p_rad     = i_rad;
                n_side[k] = i_side;
            end else begin
                p_rem     = r_rem[k-1];
                p_root    = r_root[k-1];
                p_rad     = r_rad[k-1];
                n_side[k] = r_side[k-1];
            end
            cur   = {p_rem, p_rad[RAD_W-1:RAD_W-2]};
            trial = (REM_W+2)'({p_root, 2'b01});
            if (cur >= trial) begin
                n_rem[k]  = REM_W'(cur - trial);
                n_root[k] = {p_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = cur[REM_W-1:0];
                n_root[k] = {p_root[ROOT_W-2:0], 1'b0};
            end
            n_rad[k] = p_rad << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_root = r_root[SQ_STEPS-1];
    assign o_side = r_side[SQ_STEPS-1];

endmodule

FILE: rtl/core/qrs_div.sv
// Pipelined signed fixed-point divider (num * 2^FRAC_BITS) / den, toward zero, clamped.
// Depends on qrs_pkg; one quotient bit per stage after an overflow check stage.
module qrs_div import qrs_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic [COEF_W-1:0]       o_quo,
    output logic                    o_sat
);

    localparam int N_W  = NMAG_W + FRAC_BITS;
    localparam int HI_W = N_W - DIV_STEPS;

    logic [DMAG_W-1:0]    r_rem [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_low [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_q   [DIV_STEPS+1];
    logic [DMAG_W-1:0]    r_d   [DIV_STEPS+1];
    logic                 r_neg [DIV_STEPS+1];
    logic                 r_ovf [DIV_STEPS+1];
    logic [DMAG_W-1:0]    n_rem [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] n_low [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] n_q   [DIV_STEPS+1];
    logic [COEF_W-1:0]    r_quo;
    logic                 r_sat;
    logic [COEF_W-1:0]    n_quo;
    logic                 n_sat;

    always_comb begin
        logic [NUM_W-1:0]  nabs;
        logic [N_W-1:0]    nfull;
        logic [HI_W-1:0]   hi;
        logic [DMAG_W:0]   cur;
        nabs  = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        nfull = {nabs[NMAG_W-1:0], FRAC_BITS'(0)};
        hi    = nfull[N_W-1:DIV_STEPS];
        n_rem[0] = DMAG_W'(hi);
        n_low[0] = nfull[DIV_STEPS-1:0];
        n_q[0]   = '0;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            cur = {r_rem[k-1], r_low[k-1][DIV_STEPS-1]};
            if (cur >= {1'b0, r_d[k-1]}) begin
                n_rem[k] = DMAG_W'(cur - {1'b0, r_d[k-1]});
                n_q[k]   = {r_q[k-1][DIV_STEPS-2:0], 1'b1};
            end else begin
                n_rem[k] = cur[DMAG_W-1:0];
                n_q[k]   = {r_q[k-1][DIV_STEPS-2:0], 1'b0};
            end
            n_low[k] = r_low[k-1] << 1;
        end
        if (!r_neg[DIV_STEPS]) begin
            n_sat = r_ovf[DIV_STEPS] || r_q[DIV_STEPS][DIV_STEPS-1];
            n_quo = n_sat ? 32'h7FFF_FFFF : r_q[DIV_STEPS];
        end else begin
            n_sat = r_ovf[DIV_STEPS] || (r_q[DIV_STEPS] > 32'h8000_0000);
            n_quo = n_sat ? 32'h8000_0000 : COEF_W'(-r_q[DIV_STEPS]);
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NUM_W-1:0] nabs_f;
        logic [DEN_W-1:0] dabs_f;
        logic [N_W-1:0]   nfull_f;
        if (i_en) begin
            nabs_f  = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            dabs_f  = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
            nfull_f = {nabs_f[NMAG_W-1:0], FRAC_BITS'(0)};
            r_d[0]   <= dabs_f[DMAG_W-1:0];
            r_neg[0] <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_ovf[0] <= 64'(nfull_f[N_W-1:DIV_STEPS]) >= 64'(dabs_f[DMAG_W-1:0]);
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_q[k]   <= n_q[k];
            end
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_d[k]   <= r_d[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
            r_quo <= n_quo;
            r_sat <= n_sat;
        end
    end

    assign o_quo = r_quo;
    assign o_sat = r_sat;

endmodule

FILE: rtl/core/quadratic_root_solver_top.sv
// Quadratic root solver top: zero tests, discriminant, sqrt and divider pipeline.
// Depends on qrs_pkg, qrs_isqrt and qrs_div.
//
//  channel | direction | handshake                  | beat
//  in      | input     | i_in_valid / o_in_stall    | coef_a, coef_b, coef_c
//  out     | output    | o_out_valid / i_out_stall  | root_count, roots, saturated
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | zero_tolerance
//
// One beat per cycle unless the output beat is stalled; the pipeline is 4 front stages, 33 sqrt stages,
// 1 numerator stage, 34 divider stages and the output register.
// The whole pipeline holds while the output beat is stalled.
// Synchronous active-low reset clears valid bits and sets zero_tolerance to 4295.
module quadratic_root_solver_top import qrs_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [COEF_W-1:0] i_coef_a,
    input  logic signed [COEF_W-1:0] i_coef_b,
    input  logic signed [COEF_W-1:0] i_coef_c,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_root_count,
    output logic signed [COEF_W-1:0] o_root_first,
    output logic signed [COEF_W-1:0] o_root_second,
    output logic                     o_saturated,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [TOL_W-1:0]         i_cfg_data
);

    localparam int LAT  = 4 + SQ_STEPS + 1 + DIV_LAT + 1;
    localparam int ZT_W = 2 * COEF_W - FRAC_BITS;
    localparam int DT_W = DM_W + TOL_W;

    logic             en;
    logic [LAT-1:0]   r_vld;
    logic [TOL_W-1:0] r_tol;

    // stage 1
    logic signed [COEF_W-1:0] r1_a, r1_b, r1_c;
    logic                     r1_za, r1_zb, r1_zc;
    // stage 2
    logic signed [COEF_W-1:0] r2_a, r2_b, r2_c;
    logic                     r2_za, r2_zb, r2_zc, r2_acneg;
    logic [2*COEF_W-1:0]      r2_b2, r2_ac;
    // stage 3
    logic signed [COEF_W-1:0] r3_a, r3_b, r3_c;
    logic                     r3_za, r3_zb, r3_zc, r3_dneg;
    logic [DM_W-1:0]          r3_dm;
    // stage 4
    logic [RAD_W-1:0]         r4_rad;
    t_side                    r4_side;
    t_side                    n4_side;
    // sqrt out and stage 5
    logic [ROOT_W-1:0]        sq_root;
    t_side                    sq_side;
    logic signed [NUM_W-1:0]  r5_num1, r5_num2;
    logic signed [DEN_W-1:0]  r5_den;
    t_tail                    r_tail [DIV_LAT+1];
    logic [COEF_W-1:0]        q1, q2;
    logic                     s1, s2;
    logic [1:0]               r_cnt;
    logic [COEF_W-1:0]        r_r1, r_r2;
    logic                     r_sat;

    function automatic logic is_zero(input logic signed [COEF_W-1:0] v,
                                     input logic [TOL_W-1:0] tol);
        logic [COEF_W-1:0] m;
        m = v[COEF_W-1] ? COEF_W'(-v) : COEF_W'(v);
        return {m, (COEF_W - FRAC_BITS)'(0)} <= ZT_W'(tol);
    endfunction

    assign en          = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_tol <= 32'd4295;
        end else begin
            if (en) r_vld <= {r_vld[LAT-2:0], i_in_valid};
            if (i_cfg_valid) r_tol <= i_cfg_data;
        end
    end

    always_comb begin
        logic [DT_W-1:0] lhs, rhs;
        logic            d_small;
        lhs = {r3_dm, TOL_W'(0)};
        rhs = DT_W'(r_tol) << (2 * FRAC_BITS);
        d_small = lhs <= rhs;
        n4_side = '0;
        if (r3_za) begin
            n4_side.base = -NUM_W'(r3_c);
            n4_side.den  = DEN_W'(r3_b);
            if (r3_zb && r3_zc) begin
                n4_side.tail.count = CNT_INF;
            end else if (r3_zb) begin
                n4_side.tail.count = CNT_NONE;
            end else if (r3_zc) begin
                n4_side.tail.count = CNT_ONE;
            end else begin
                n4_side.tail.count = CNT_ONE;
                n4_side.tail.use1  = 1'b1;
            end
        end else begin
            n4_side.base = -NUM_W'(r3_b);
            n4_side.den  = DEN_W'(r3_a) <<< 1;
            if (d_small) begin
                n4_side.tail.count = CNT_ONE;
                n4_side.tail.use1  = 1'b1;
            end else if (!r3_dneg) begin
                n4_side.tail.count = CNT_TWO;
                n4_side.tail.use1  = 1'b1;
                n4_side.tail.use2  = 1'b1;
                n4_side.two        = 1'b1;
            end else begin
                n4_side.tail.count = CNT_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [COEF_W-1:0]   ma, mb, mc;
        logic [2*COEF_W+1:0] ac4, b2;
        logic signed [NUM_W-1:0] sx;
        if (en) begin
            r1_a  <= i_coef_a;
            r1_b  <= i_coef_b;
            r1_c  <= i_coef_c;
            r1_za <= is_zero(i_coef_a, r_tol);
            r1_zb <= is_zero(i_coef_b, r_tol);
            r1_zc <= is_zero(i_coef_c, r_tol);

            ma = r1_a[COEF_W-1] ? COEF_W'(-r1_a) : COEF_W'(r1_a);
            mb = r1_b[COEF_W-1] ? COEF_W'(-r1_b) : COEF_W'(r1_b);
            mc = r1_c[COEF_W-1] ? COEF_W'(-r1_c) : COEF_W'(r1_c);
            r2_b2    <= mb * mb;
            r2_ac    <= ma * mc;
            r2_acneg <= r1_a[COEF_W-1] ^ r1_c[COEF_W-1];
            r2_a  <= r1_a;  r2_b  <= r1_b;  r2_c  <= r1_c;
            r2_za <= r1_za; r2_zb <= r1_zb; r2_zc <= r1_zc;

            ac4 = {r2_ac, 2'b00};
            b2  = (2*COEF_W+2)'(r2_b2);
            if (r2_acneg) begin
                r3_dm   <= DM_W'(b2 + ac4);
                r3_dneg <= 1'b0;
            end else if (b2 >= ac4) begin
                r3_dm   <= DM_W'(b2 - ac4);
                r3_dneg <= 1'b0;
            end else begin
                r3_dm   <= DM_W'(ac4 - b2);
                r3_dneg <= 1'b1;
            end
            r3_a  <= r2_a;  r3_b  <= r2_b;  r3_c  <= r2_c;
            r3_za <= r2_za; r3_zb <= r2_zb; r3_zc <= r2_zc;

            r4_rad  <= {1'b0, r3_dm};
            r4_side <= n4_side;

            sx = NUM_W'({2'b00, sq_root});
            r5_num1   <= sq_side.two ? sq_side.base + sx : sq_side.base;
            r5_num2   <= sq_side.base - sx;
            r5_den    <= sq_side.den;
            r_tail[0] <= sq_side.tail;
            for (int k = 1; k <= DIV_LAT; k++) r_tail[k] <= r_tail[k-1];

            r_cnt <= r_tail[DIV_LAT].count;
            r_r1  <= r_tail[DIV_LAT].use1 ? q1 : '0;
            r_r2  <= r_tail[DIV_LAT].use2 ? q2 : '0;
            r_sat <= (r_tail[DIV_LAT].use1 && s1) || (r_tail[DIV_LAT].use2 && s2);
        end
    end

    qrs_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r4_rad),
        .i_side (r4_side),
        .o_root (sq_root),
        .o_side (sq_side)
    );

    qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r5_num1),
        .i_den (r5_den),
        .o_quo (q1),
        .o_sat (s1)
    );

    qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r5_num2),
        .i_den (r5_den),
        .o_quo (q2),
        .o_sat (s2)
    );

    assign o_out_valid   = r_vld[LAT-1];
    assign o_root_count  = r_cnt;
    assign o_root_first  = r_r1;
    assign o_root_second = r_r2;
    assign o_saturated   = r_sat;

`ifndef SYNTHESIS
    a_no_roots_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_root_count == CNT_NONE || o_root_count == CNT_INF)
        |-> o_root_first == '0 && o_root_second == '0 && !o_saturated)
        else $error("roots nonzero with no finite root");
    a_second_only_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_root_count != CNT_TWO |-> o_root_second == '0)
        else $error("second root set without two roots");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

FILE: dv/tb_top.sv
// Testbench for quadratic_root_solver_top: random and directed coefficient sets,
// results checked against an in-bench fixed-point predictor. Depends on qrs_pkg and quadratic_root_solver_top.
module tb_top;
    import qrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam int LAT = 80;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  count;
        logic [31:0] first;
        logic [31:0] second;
        logic        sat;
    } t_roots;

    logic i_clk = 0, i_rst_n = 0;
    logic i_in_valid = 0, i_out_stall = 0, i_cfg_valid = 0;
    logic signed [31:0] i_coef_a = 0, i_coef_b = 0, i_coef_c = 0;
    logic [31:0] i_cfg_data = 0;
    logic o_in_stall, o_out_valid, o_saturated, o_cfg_ready;
    logic [1:0] o_root_count;
    logic signed [31:0] o_root_first, o_root_second;

    logic [31:0] tol = 32'd4295;
    t_roots roots_due[$];
    bit failed = 0;
    longint cycles = 0;

    quadratic_root_solver_top #(.FRAC_BITS(FB)) u_top (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[quadratic_root_solver_top] ERROR");
            $finish;
        end
    end

    function automatic bit is_zero(logic signed [31:0] v);
        logic [63:0] m;
        m = v < 0 ? -64'(v) : 64'(v);
        return (m << (32 - FB)) <= {32'd0, tol};
    endfunction

    function automatic logic [31:0] qdiv(logic signed [63:0] num,
                                         logic signed [63:0] den, inout logic sat);
        logic [63:0] q;
        logic [63:0] nm, dm;
        nm = num < 0 ? -num : num;
        dm = den < 0 ? -den : den;
        q = (nm << FB) / dm;
        if ((num < 0) == (den < 0)) begin
            if (q > 64'h7FFF_FFFF) begin
                sat = 1;
                return 32'h7FFF_FFFF;
            end
            return q[31:0];
        end
        if (q > 64'h8000_0000) begin
            sat = 1;
            return 32'h8000_0000;
        end
        return 32'(-q);
    endfunction

    function automatic t_roots solve_roots(logic signed [31:0] a, b, c);
        t_roots r;
        logic signed [127:0] d;
        logic [127:0] dm, s, t;
        r = '0;
        if (is_zero(a)) begin
            if (is_zero(b) && is_zero(c)) r.count = CNT_INF;
            else if (is_zero(b)) r.count = CNT_NONE;
            else if (is_zero(c)) r.count = CNT_ONE;
            else begin
                r.count = CNT_ONE;
                r.first = qdiv(-64'(c), 64'(b), r.sat);
            end
        end else begin
            d = 128'(b) * 128'(b) - 4 * 128'(a) * 128'(c);
            dm = d < 0 ? -d : d;
            if ((dm << (32 - 2 * FB)) <= 128'(tol)) begin
                r.count = CNT_ONE;
                r.first = qdiv(-64'(b), 2 * 64'(a), r.sat);
            end else if (d > 0) begin
                s = 0;
                for (int i = 34; i >= 0; i--) begin
                    t = s | (128'd1 << i);
                    if (t * t <= dm) s = t;
                end
                r.count = CNT_TWO;
                r.first = qdiv(-64'(b) + 64'(s), 2 * 64'(a), r.sat);
                r.second = qdiv(-64'(b) - 64'(s), 2 * 64'(a), r.sat);
            end
        end
        return r;
    endfunction

    task automatic send_coefs(logic signed [31:0] a, b, c, bit gaps = 1);
        int w;
        w = gaps ? $urandom_range(0, 14) : 0;
        if (w != 0) begin
            i_in_valid <= 0;
            repeat (w) @(negedge i_clk);
        end
        i_coef_a <= a;
        i_coef_b <= b;
        i_coef_c <= c;
        i_in_valid <= 1;
        do @(posedge i_clk); while (o_in_stall);
        roots_due.push_back(solve_roots(a, b, c));
        @(negedge i_clk);
    endtask

    task automatic drain();
        int n;
        i_in_valid <= 0;
        n = 0;
        while (roots_due.size() != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (LAT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_tolerance(logic [31:0] v);
        drain();
        i_cfg_data <= v;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        tol = v;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // output side: random stall per beat, then compare
    initial begin
        t_roots e;
        int w;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            if (w != 0) begin
                i_out_stall <= 1;
                repeat (w) @(negedge i_clk);
                i_out_stall <= 0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            if (roots_due.size() == 0) begin
                $error("result beat with nothing expected");
                failed = 1;
            end else begin
                e = roots_due.pop_front();
                if (o_root_count !== e.count) begin
                    $error("root_count exp %0d got %0d", e.count, o_root_count);
                    failed = 1;
                end
                if (o_root_first !== e.first) begin
                    $error("root_first exp %h got %h", e.first, o_root_first);
                    failed = 1;
                end
                if (o_root_second !== e.second) begin
                    $error("root_second exp %h got %h", e.second, o_root_second);
                    failed = 1;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %0d got %0d", e.sat, o_saturated);
                    failed = 1;
                end
            end
        end
    end

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 8)) - 4);
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_linear();
        send_coefs(0, 0, 0);
        send_coefs(0, 0, 32'h0001_0000);
        send_coefs(0, 32'h0002_0000, 0);
        send_coefs(0, 32'h0002_0000, 32'h0006_0000);
        send_coefs(0, 1, 32'h7FFF_FFFF);
        send_coefs(0, -1, 32'h8000_0000);
        send_coefs(0, 32'h8000_0000, 32'h7FFF_FFFF);
    endtask

    task automatic test_quadratic();
        send_coefs(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
        send_coefs(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);
        send_coefs(32'h0001_0000, 0, 32'h0001_0000);
        send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_coefs(1, 32'h7FFF_FFFF, 1);
        send_coefs(-1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_tolerance();
        set_tolerance(0);
        send_coefs(0, 1, 1);
        send_coefs(1, 0, 0);
        send_coefs(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);
        set_tolerance(32'hFFFF_FFFF);
        send_coefs(32'h0000_FFFF, 32'h0001_0000, 5);
        send_coefs(32'h0001_0000, 32'h0000_8000, 0);
        set_tolerance(32'd4295);
    endtask

    task automatic test_random();
        logic [31:0] tols [4];
        tols = '{32'd4295, 32'd0, 32'h0001_0000, 32'hFFFF_FFFF};
        for (int p = 0; p < 4; p++) begin
            set_tolerance(p == 3 ? $urandom : tols[p]);
            for (int i = 0; i < 375; i++)
                send_coefs(pick_coef(), pick_coef(), pick_coef(), i % 100 < 70);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        test_linear();
        test_quadratic();
        test_tolerance();
        test_random();
        drain();
        if (!failed) $display("[quadratic_root_solver_top] OK");
        else $display("[quadratic_root_solver_top] ERROR");
        $finish;
    end
endmodule
